/* design/bmhq_pkg.sv */
package bmhq_pkg;

    localparam int VALUE_W          = 32;
    localparam int ENTRY_W          = 11;
    localparam int STATUS_W         = 2;
    localparam int DEFAULT_CAPACITY = 1024;
    localparam int RESULT_W         = VALUE_W + ENTRY_W + STATUS_W;
    localparam int M_TDATA_W        = ((RESULT_W + 7) / 8) * 8;
    localparam int PAD_W            = M_TDATA_W - RESULT_W;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_POP    = 1'b1
    } bmhq_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } bmhq_status_t;

    // Operation broadcast to every cell; both low leaves the row unchanged.
    typedef struct packed {
        logic ins;
        logic pop;
    } bmhq_op_t;

    // Result word as it leaves on m_tdata, top_value in the lowest bits.
    typedef struct packed {
        logic [PAD_W-1:0]          pad;
        bmhq_status_t              status;
        logic [ENTRY_W-1:0]        entry_count;
        logic signed [VALUE_W-1:0] top_value;
    } bmhq_result_t;

endpackage

/* design/bmhq_cell.sv */
module bmhq_cell
    import bmhq_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 11
) (
    input  logic                      aclk,
    input  bmhq_op_t                  op,
    input  logic signed [VALUE_W-1:0] new_value,
    input  logic signed [VALUE_W-1:0] prev_value,
    input  logic signed [VALUE_W-1:0] next_value,
    input  logic                      prev_gt,
    input  logic [CNT_W-1:0]          count,
    output logic signed [VALUE_W-1:0] value,
    output logic                      gt
);

    logic signed [VALUE_W-1:0] key_reg;
    logic signed [VALUE_W-1:0] key_next;
    logic                      occupied;

    // The row is kept sorted from the largest key down, so the cells that
    // hold a smaller key than the new one, or nothing, form a suffix.
    assign occupied = CNT_W'(INDEX) < count;
    assign gt       = !occupied || (new_value > key_reg);
    assign value    = key_reg;

    always_comb begin
        key_next = key_reg;
        if (op.pop) begin
            key_next = next_value;
        end else if (op.ins && gt) begin
            key_next = prev_gt ? prev_value : new_value;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

/* design/binary_max_heap_queue.sv */
// Priority queue of signed 32-bit keys that returns the largest key held.
// Each request on s_ is an insert (s_tuser low, key in s_tdata) or a pop
// (s_tuser high) and produces exactly one result on m_: the popped maximum,
// or the current maximum after an insert, the entry count after the request
// and a status. An insert into a full queue and a pop from an empty one are
// rejected with status 1 and 2 and leave the contents alone; a rejected pop
// reports a key of zero. The keys live in a row of CAPACITY cells kept in
// descending order; each cell takes its new key from itself, a neighbor or
// the new key, so every request is executed at the edge that accepts it.
// Its result is registered there and offered on m_ from the following cycle,
// or kept in the skid register while an earlier result still waits. One
// request per clock cycle is sustained while m_tready is high; a two-deep
// result buffer keeps s_tready high while one result waits on a stalled
// m_tready, drops it only once a second waits; reset needs no clearing pass.
module binary_max_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [VALUE_W-1:0]   s_tdata,   // value[31:0]
    input  logic                 s_tuser,   // cmd[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // top_value[31:0], entry_count[42:32],
                                            // status[44:43], zero[47:45]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    bmhq_result_t      out_data_reg;
    bmhq_result_t      out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    bmhq_result_t      skid_data_reg;
    bmhq_result_t      skid_data_next;

    logic                      accept;
    logic                      deliver;
    logic                      is_pop;
    logic                      full;
    logic                      empty;
    logic signed [VALUE_W-1:0] new_value;
    bmhq_op_t                  op;
    bmhq_result_t              result;
    logic [CNT_W+ENTRY_W-1:0]  count_ext;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic                      cell_gt    [CAPACITY];

    assign accept    = s_tvalid && s_tready;
    assign deliver   = m_tvalid && m_tready;
    assign is_pop    = bmhq_cmd_t'(s_tuser) == CMD_POP;
    assign full      = cnt_reg == CNT_W'(CAPACITY);
    assign empty     = cnt_reg == '0;
    assign new_value = $signed(s_tdata);

    // Insert flag first, pop flag second, as in the struct.
    assign op = {accept && !is_pop && !full, accept && is_pop && !empty};

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [VALUE_W-1:0] prev_value;
            logic signed [VALUE_W-1:0] next_value;
            logic                      prev_gt;

            if (gi == 0) begin : g_first
                assign prev_value = new_value;
                assign prev_gt    = 1'b0;
            end else begin : g_inner
                assign prev_value = cell_value[gi-1];
                assign prev_gt    = cell_gt[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign next_value = cell_value[gi];
            end else begin : g_body
                assign next_value = cell_value[gi+1];
            end

            bmhq_cell #(
                .INDEX (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk       (aclk),
                .op         (op),
                .new_value  (new_value),
                .prev_value (prev_value),
                .next_value (next_value),
                .prev_gt    (prev_gt),
                .count      (cnt_reg),
                .value      (cell_value[gi]),
                .gt         (cell_gt[gi])
            );
        end
    endgenerate

    always_comb begin
        cnt_next = cnt_reg;
        if (op.ins) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (op.pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // The count after the request, cut or padded to the result field.
    assign count_ext = {{ENTRY_W{1'b0}}, cnt_next};

    always_comb begin
        result             = '0;
        result.entry_count = count_ext[ENTRY_W-1:0];
        if (is_pop) begin
            if (empty) begin
                result.status    = ST_EMPTY;
                result.top_value = '0;
            end else begin
                result.status    = ST_OK;
                result.top_value = cell_value[0];
            end
        end else if (full) begin
            result.status    = ST_FULL;
            result.top_value = cell_value[0];
        end else begin
            result.status    = ST_OK;
            result.top_value = (empty || cell_gt[0]) ? new_value : cell_value[0];
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (deliver) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || deliver) begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end else if (deliver) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* design/bmhq_checker.sv */
module bmhq_checker
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [VALUE_W-1:0]   s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    bmhq_result_t res;

    assign res = m_tdata;

    // No result may appear in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A rejected pop leaves an empty queue and reports a zero key.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status == ST_EMPTY |-> res.entry_count == '0 && res.top_value == '0)
        else $error("empty rejection with nonzero count or key");

    // A rejected insert only happens with the queue at capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status == ST_FULL |-> res.entry_count == ENTRY_W'(CAPACITY))
        else $error("full rejection below capacity");

endmodule

bind binary_max_heap_queue bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (.*);

/* tb/tb_binary_max_heap_queue.sv */
`timescale 1ns / 1ps

module tb_binary_max_heap_queue;
    import bmhq_pkg::*;

    localparam int HEAP_CAP = DEFAULT_CAPACITY;

    typedef struct {
        bmhq_cmd_t             op;
        logic [VALUE_W-1:0]    key;
        bit                    typed;
        logic [VALUE_W-1:0]    top;
        logic [ENTRY_W-1:0]    count;
        bmhq_status_t          status;
    } stim_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [VALUE_W-1:0]   s_tdata  = '0;   // value[31:0]
    logic                 s_tuser  = 1'b0; // cmd[0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // top_value[31:0], entry_count[42:32],
                                           // status[44:43], zero[47:45]

    binary_max_heap_queue #(
        .CAPACITY(HEAP_CAP)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Predicted contents of the queue.
    logic signed [VALUE_W-1:0] heap_keys [1:HEAP_CAP];
    int                        keys_held = 0;

    bmhq_result_t expected_results [$];
    stim_row_t    fixed_answers [$];

    int inserts_done   = 0;
    int pops_done      = 0;
    int full_rejects   = 0;
    int empty_rejects  = 0;
    int peak_fill      = 0;
    int results_seen   = 0;
    int mismatch_count = 0;

    // Driver-side view of the fill level, used only to steer the stimulus.
    int shadow_fill = 0;
    int full_hits   = 0;
    int send_quiet  = 0;
    int recv_quiet  = 0;

    function automatic bmhq_result_t predict_heap_request(bmhq_cmd_t op,
                                                          logic signed [VALUE_W-1:0] key);
        bmhq_result_t              r;
        int                        pos;
        int                        child;
        logic signed [VALUE_W-1:0] t;
        r = '0;
        r.status = ST_OK;
        if (op == CMD_INSERT) begin
            if (keys_held >= HEAP_CAP) begin
                r.status = ST_FULL;
                full_rejects++;
            end else begin
                keys_held++;
                inserts_done++;
                heap_keys[keys_held] = key;
                pos = keys_held;
                while (pos > 1 && heap_keys[pos] > heap_keys[pos / 2]) begin
                    t = heap_keys[pos];
                    heap_keys[pos] = heap_keys[pos / 2];
                    heap_keys[pos / 2] = t;
                    pos = pos / 2;
                end
            end
            if (keys_held > 0)
                r.top_value = heap_keys[1];
        end else if (keys_held == 0) begin
            r.status = ST_EMPTY;
            empty_rejects++;
        end else begin
            pops_done++;
            r.top_value = heap_keys[1];
            heap_keys[1] = heap_keys[keys_held];
            keys_held--;
            pos = 1;
            while (2 * pos <= keys_held) begin
                child = 2 * pos;
                // The right child only counts when it exists; ties go left.
                if (child + 1 <= keys_held && heap_keys[child + 1] > heap_keys[child])
                    child++;
                if (!(heap_keys[child] > heap_keys[pos]))
                    break;
                t = heap_keys[pos];
                heap_keys[pos] = heap_keys[child];
                heap_keys[child] = t;
                pos = child;
            end
        end
        if (keys_held > peak_fill)
            peak_fill = keys_held;
        r.entry_count = keys_held[ENTRY_W-1:0];
        return r;
    endfunction

    // Random pauses between items, with occasional stretches of none.
    function automatic int draw_pause(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
            quiet_left = $urandom_range(8, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return VALUE_W'($signed($urandom_range(0, 8)) - 4);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_request(input stim_row_t row);
        int pause;
        pause = draw_pause(send_quiet);
        if (pause > 0) begin
            s_tvalid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        fixed_answers.push_back(row);
        s_tvalid <= 1'b1;
        s_tuser  <= row.op;
        s_tdata  <= row.key;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (row.op == CMD_INSERT) begin
            if (shadow_fill == HEAP_CAP) full_hits++;
            else shadow_fill++;
        end else begin
            if (shadow_fill > 0) shadow_fill--;
        end
    endtask

    task automatic send_random(input int insert_pct);
        stim_row_t row;
        row = '{CMD_INSERT, '0, 1'b0, '0, '0, ST_OK};
        row.op  = ($urandom_range(1, 100) <= insert_pct) ? CMD_INSERT : CMD_POP;
        row.key = pick_key();
        send_request(row);
    endtask

    // Every accepted request is predicted at its own edge; results are checked in order.
    always @(posedge aclk) begin : watch
        bmhq_result_t exp;
        bmhq_result_t got;
        stim_row_t    row;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                exp = predict_heap_request(bmhq_cmd_t'(s_tuser), s_tdata);
                if (fixed_answers.size() > 0) begin
                    row = fixed_answers.pop_front();
                    if (row.typed) begin
                        exp.top_value   = row.top;
                        exp.entry_count = row.count;
                        exp.status      = row.status;
                    end
                end
                expected_results.push_back(exp);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: top %0d count %0d status %0d",
                                 got.top_value, got.entry_count, got.status);
                end else begin
                    exp = expected_results.pop_front();
                    if (got.top_value !== exp.top_value || got.entry_count !== exp.entry_count
                            || got.status !== exp.status || got.pad !== '0) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result %0d mismatch: expected top %0d count %0d status %0d",
                                     results_seen, exp.top_value, exp.entry_count,
                                     exp.status);
                            $display("    got top %0d count %0d status %0d pad %0h",
                                     got.top_value, got.entry_count, got.status, got.pad);
                        end
                    end
                end
            end
        end
    end

    initial begin : result_ready
        int stall;
        wait (aresetn);
        forever begin
            stall = draw_pause(recv_quiet);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        stim_row_t directed_rows [23];
        directed_rows = '{
            '{CMD_POP,    32'h0000_0000, 1, 32'h0000_0000, 11'd0, ST_EMPTY},
            '{CMD_INSERT, 32'h8000_0000, 1, 32'h8000_0000, 11'd1, ST_OK},
            '{CMD_INSERT, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 11'd2, ST_OK},
            '{CMD_INSERT, 32'h0000_0000, 1, 32'h7FFF_FFFF, 11'd3, ST_OK},
            '{CMD_INSERT, 32'hFFFF_FFFF, 0, '0, '0, ST_OK},
            '{CMD_INSERT, 32'h0000_0005, 0, '0, '0, ST_OK},
            '{CMD_INSERT, 32'h0000_0005, 0, '0, '0, ST_OK},
            '{CMD_INSERT, 32'h7FFF_FFFF, 0, '0, '0, ST_OK},
            '{CMD_INSERT, 32'hFFFF_FFF9, 0, '0, '0, ST_OK},
            '{CMD_POP,    32'hAAAA_AAAA, 0, '0, '0, ST_OK},
            '{CMD_POP,    32'h5555_5555, 0, '0, '0, ST_OK},
            '{CMD_POP,    32'hFFFF_FFFF, 0, '0, '0, ST_OK},
            '{CMD_POP,    32'h0000_0000, 0, '0, '0, ST_OK},
            '{CMD_POP,    32'h0000_0000, 0, '0, '0, ST_OK},
            '{CMD_POP,    32'h0000_0000, 0, '0, '0, ST_OK},
            '{CMD_POP,    32'h0000_0000, 0, '0, '0, ST_OK},
            '{CMD_POP,    32'h0000_0000, 0, '0, '0, ST_OK},
            '{CMD_POP,    32'h0000_0000, 1, 32'h0000_0000, 11'd0, ST_EMPTY},
            '{CMD_INSERT, 32'h8000_0000, 1, 32'h8000_0000, 11'd1, ST_OK},
            '{CMD_INSERT, 32'h8000_0000, 0, '0, '0, ST_OK},
            '{CMD_POP,    32'h0000_0000, 0, '0, '0, ST_OK},
            '{CMD_POP,    32'h0000_0000, 0, '0, '0, ST_OK},
            '{CMD_POP,    32'hFFFF_FFFF, 1, 32'h0000_0000, 11'd0, ST_EMPTY}
        };
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        // Fill to capacity and push against the full limit.
        while (shadow_fill < HEAP_CAP || full_hits < 8)
            send_random(97);
        // Drain most of the way with mostly pops.
        repeat (780)
            send_random(10);
        s_tvalid <= 1'b0;

        while (expected_results.size() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d inserts and %0d pops done, %0d full and %0d empty rejections",
                 inserts_done, pops_done, full_rejects, empty_rejects);
        $display("largest fill %0d of %0d, %0d results checked, %0d mismatches",
                 peak_fill, HEAP_CAP, results_seen, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
design/bmhq_pkg.sv
design/bmhq_cell.sv
design/binary_max_heap_queue.sv
design/bmhq_checker.sv
tb/tb_binary_max_heap_queue.sv
